// ===== rtl/core/exif_tiff_header_locator_core_defines.svh =====
// assertion macros for the exif tiff header locator core
`ifndef EXIF_TIFF_HEADER_LOCATOR_CORE_DEFINES_SVH
`define EXIF_TIFF_HEADER_LOCATOR_CORE_DEFINES_SVH

// condition implies consequence in the same cycle, off while in reset
`define ETHL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle, off while in reset
`define ETHL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/exif_thl_pkg.sv =====
// shared types for the exif tiff header locator
`default_nettype none

package exif_thl_pkg;

  // answer codes
  typedef enum logic [1:0] {
    ST_FOUND      = 2'd0,
    ST_NO_EXIF    = 2'd1,
    ST_BAD_HEADER = 2'd2,
    ST_TOO_SHORT  = 2'd3
  } status_t;

  // one answer word
  typedef struct packed {
    status_t     status;
    logic        little_endian;
    logic [31:0] header_position;
    logic [31:0] first_ifd_offset;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/exif_thl_parser.sv =====
// byte-wise jpeg segment walker and tiff header decoder
`default_nettype none

module exif_thl_parser #(
  parameter int POSITION_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  accept,
  input  wire logic [7:0]            data_byte,
  input  wire logic                  end_of_file,
  output logic                       res_vld,
  output exif_thl_pkg::result_t      res
);
  import exif_thl_pkg::*;

  localparam int EXT_BITS = 64 - POSITION_BITS;

  localparam logic [7:0] BYTE_PREFIX = 8'hFF;
  localparam logic [7:0] BYTE_SOI    = 8'hD8;
  localparam logic [7:0] BYTE_APP1   = 8'hE1;
  localparam logic [7:0] BYTE_SOS    = 8'hDA;
  localparam logic [7:0] BYTE_II     = 8'h49;
  localparam logic [7:0] BYTE_MM     = 8'h4D;
  localparam logic [15:0] TIFF_MAGIC = 16'd42;
  localparam logic [15:0] MIN_LEN    = 16'd2;
  localparam logic [15:0] MIN_APP1   = 16'd8;
  localparam logic [2:0]  SIG_LAST   = 3'd5;
  localparam logic [2:0]  HDR_LAST   = 3'd7;

  typedef enum logic [3:0] {
    PH_FIRST, PH_SECOND, PH_PREFIX, PH_MARKER, PH_LEN_HI,
    PH_LEN_LO, PH_SIG, PH_SKIP, PH_HEADER, PH_DONE
  } phase_t;

  // exif signature "Exif" 00 00
  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] val;
    unique case (idx)
      3'd0:    val = 8'h45;
      3'd1:    val = 8'h78;
      3'd2:    val = 8'h69;
      3'd3:    val = 8'h66;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  phase_t                     phase_r, phase_nxt;
  logic [POSITION_BITS-1:0]   count_r, count_nxt;
  logic [7:0]                 held_r, held_nxt;
  logic [7:0]                 marker_r, marker_nxt;
  logic [15:0]                skip_r, skip_nxt;
  logic                       sig_ok_r, sig_ok_nxt;
  logic [2:0]                 idx_r, idx_nxt;
  logic                       little_r, little_nxt;
  logic [15:0]                magic_r, magic_nxt;
  logic [31:0]                offset_r, offset_nxt;
  logic [POSITION_BITS-1:0]   start_r, start_nxt;

  logic                       dec;
  status_t                    dec_status;
  result_t                    res_c;

  // next state and answer for the byte on the input
  always_comb begin
    logic [15:0] len;
    logic        sig_new;
    logic [63:0] start_ext;
    phase_nxt  = phase_r;
    count_nxt  = count_r + 1'b1;
    held_nxt   = held_r;
    marker_nxt = marker_r;
    skip_nxt   = skip_r;
    sig_ok_nxt = sig_ok_r;
    idx_nxt    = idx_r;
    little_nxt = little_r;
    magic_nxt  = magic_r;
    offset_nxt = offset_r;
    start_nxt  = start_r;
    dec        = 1'b0;
    dec_status = ST_NO_EXIF;
    len        = {held_r, data_byte};
    sig_new    = sig_ok_r & (data_byte == sig_byte(idx_r));
    start_ext  = {{EXT_BITS{1'b0}}, start_r};

    unique case (phase_r)
      PH_FIRST: begin
        held_nxt  = data_byte;
        phase_nxt = PH_SECOND;
      end
      PH_SECOND: begin
        if (held_r == BYTE_PREFIX && data_byte == BYTE_SOI) begin
          phase_nxt = PH_PREFIX;
        end else begin
          // no jpeg: first two bytes are the byte order mark
          start_nxt  = '0;
          sig_ok_nxt = (held_r == data_byte) &&
                       (data_byte == BYTE_II || data_byte == BYTE_MM);
          little_nxt = (data_byte == BYTE_II);
          idx_nxt    = 3'd2;
          magic_nxt  = '0;
          offset_nxt = '0;
          phase_nxt  = PH_HEADER;
        end
      end
      PH_PREFIX: begin
        if (data_byte != BYTE_PREFIX) dec = 1'b1;
        else phase_nxt = PH_MARKER;
      end
      PH_MARKER: begin
        marker_nxt = data_byte;
        if (data_byte == BYTE_SOS) dec = 1'b1;
        else phase_nxt = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        held_nxt  = data_byte;
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if (len < MIN_LEN) begin
          dec = 1'b1;
        end else begin
          skip_nxt = len - MIN_LEN;
          if (marker_r == BYTE_APP1 && len >= MIN_APP1) begin
            idx_nxt    = '0;
            sig_ok_nxt = 1'b1;
            phase_nxt  = PH_SIG;
          end else begin
            phase_nxt = (len != MIN_LEN) ? PH_SKIP : PH_PREFIX;
          end
        end
      end
      PH_SIG: begin
        skip_nxt   = skip_r - 1'b1;
        idx_nxt    = idx_r + 1'b1;
        sig_ok_nxt = sig_new;
        if (idx_r == SIG_LAST) begin
          if (sig_new) begin
            if (end_of_file) begin
              dec = 1'b1;
            end else begin
              // tiff header opens on the next byte
              start_nxt  = count_r + 1'b1;
              idx_nxt    = '0;
              sig_ok_nxt = 1'b1;
              magic_nxt  = '0;
              offset_nxt = '0;
              phase_nxt  = PH_HEADER;
            end
          end else begin
            idx_nxt   = '0;
            phase_nxt = (skip_nxt != '0) ? PH_SKIP : PH_PREFIX;
          end
        end
      end
      PH_SKIP: begin
        skip_nxt = skip_r - 1'b1;
        if (skip_nxt == '0) phase_nxt = PH_PREFIX;
      end
      PH_HEADER: begin
        idx_nxt = idx_r + 1'b1;
        if (idx_r == 3'd0) begin
          held_nxt = data_byte;
        end else if (idx_r == 3'd1) begin
          sig_ok_nxt = (held_r == data_byte) &&
                       (data_byte == BYTE_II || data_byte == BYTE_MM);
          little_nxt = (data_byte == BYTE_II);
        end else if (idx_r <= 3'd3) begin
          magic_nxt = little_r ? {data_byte, magic_r[15:8]} : {magic_r[7:0], data_byte};
        end else begin
          offset_nxt = little_r ? {data_byte, offset_r[31:8]} : {offset_r[23:0], data_byte};
        end
        if (idx_r == HDR_LAST) begin
          dec        = 1'b1;
          dec_status = (sig_ok_r && magic_r == TIFF_MAGIC) ? ST_FOUND : ST_BAD_HEADER;
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase

    // end of file forces an answer if none was given yet
    if (end_of_file && !dec && phase_r != PH_DONE) begin
      dec        = 1'b1;
      dec_status = (phase_nxt == PH_HEADER || phase_nxt == PH_FIRST ||
                    phase_nxt == PH_SECOND) ? ST_TOO_SHORT : ST_NO_EXIF;
    end
    if (end_of_file && count_r < POSITION_BITS'(3)) begin
      dec        = 1'b1;
      dec_status = ST_TOO_SHORT;
    end

    // answer word, payload only on a found header
    res_c.status = dec_status;
    if (dec_status == ST_FOUND) begin
      res_c.little_endian    = little_r;
      res_c.header_position  = start_ext[31:0];
      res_c.first_ifd_offset = offset_nxt;
    end else begin
      res_c.little_endian    = 1'b0;
      res_c.header_position  = '0;
      res_c.first_ifd_offset = '0;
    end

    if (dec) phase_nxt = PH_DONE;
  end

  assign res_vld = accept & dec;
  assign res     = res_c;

  // walker state, back to reset after the final byte of a file
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && end_of_file)) begin
      phase_r  <= PH_FIRST;
      count_r  <= '0;
      held_r   <= '0;
      marker_r <= '0;
      skip_r   <= '0;
      sig_ok_r <= 1'b1;
      idx_r    <= '0;
      little_r <= 1'b0;
      magic_r  <= '0;
      offset_r <= '0;
      start_r  <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      held_r   <= held_nxt;
      marker_r <= marker_nxt;
      skip_r   <= skip_nxt;
      sig_ok_r <= sig_ok_nxt;
      idx_r    <= idx_nxt;
      little_r <= little_nxt;
      magic_r  <= magic_nxt;
      offset_r <= offset_nxt;
      start_r  <= start_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/exif_thl_outq.sv =====
// two-word result queue between the parser and the output channel
`default_nettype none

module exif_thl_outq (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire exif_thl_pkg::result_t push_word,
  input  wire logic                  out_stall,
  output logic                       out_valid,
  output exif_thl_pkg::result_t      out_word,
  output logic                       full
);
  import exif_thl_pkg::*;

  result_t     q_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        pop;

  assign out_valid = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign out_word  = q_r[rd_ptr_r];
  assign pop       = out_valid & ~out_stall;

  // storage
  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= push_word;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      if (push && !pop)      cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/exif_tiff_header_locator_core.sv =====
// top level of the exif tiff header locator
//
//  channel  direction  handshake           word
//  in_      input      in_valid/in_stall   data_byte, end_of_file
//  out_     output     out_valid/out_stall status, little_endian, header_position,
//                                          first_ifd_offset
//
// one byte is taken per cycle unless in_stall is high; the answer is queued with the byte that settles it
// a two-word result queue sets the stall: in_stall is high only while both entries wait
// synchronous active-low reset empties the queue and restarts the walker at a new file
// after the final byte of a file all walker state returns to its reset values
`default_nettype none
`include "exif_tiff_header_locator_core_defines.svh"

module exif_tiff_header_locator_core #(
  parameter int POSITION_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_file,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic             out_little_endian,
  output logic [31:0]      out_header_position,
  output logic [31:0]      out_first_ifd_offset
);
  import exif_thl_pkg::*;

  logic    in_accept;
  logic    res_vld;
  result_t res_word;
  result_t out_word;
  logic    q_full;

  assign in_stall  = q_full;
  assign in_accept = in_valid & ~in_stall;

  // segment walker and header decoder
  exif_thl_parser #(
    .POSITION_BITS (POSITION_BITS)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .data_byte   (in_data_byte),
    .end_of_file (in_end_of_file),
    .res_vld     (res_vld),
    .res         (res_word)
  );

  // result queue
  exif_thl_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_vld),
    .push_word (res_word),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word),
    .full      (q_full)
  );

  assign out_status           = out_word.status;
  assign out_little_endian    = out_word.little_endian;
  assign out_header_position  = out_word.header_position;
  assign out_first_ifd_offset = out_word.first_ifd_offset;

  // checks
  `ETHL_ASSERT_SAME(a_push_not_full, res_vld, !q_full, "result pushed into a full queue")
  `ETHL_ASSERT_SAME(a_stall_has_word, in_stall, out_valid, "input stalled with no word waiting")
  `ETHL_ASSERT_SAME(a_fail_payload_zero, out_valid && out_status != ST_FOUND, out_little_endian == 1'b0 && out_header_position == '0 && out_first_ifd_offset == '0, "failed answer carries payload")
  `ETHL_ASSERT_NEXT(a_push_shows, res_vld, out_valid, "pushed result not visible")

endmodule

`default_nettype wire

// ===== test/tb_exif_tiff_header_locator_core.sv =====
// self-checking testbench for the exif tiff header locator core
`timescale 1ns / 100ps

module tb_exif_tiff_header_locator_core;
  import exif_thl_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_BYTES = 700;
  localparam int RANDOM_FILES = 40;
  localparam int TAIL_CYCLES  = 8;

  // jpeg and tiff byte codes
  localparam logic [7:0]  MARK_PREFIX    = 8'hFF;
  localparam logic [7:0]  MARK_SOI       = 8'hD8;
  localparam logic [7:0]  MARK_APP0      = 8'hE0;
  localparam logic [7:0]  MARK_APP1      = 8'hE1;
  localparam logic [7:0]  MARK_SOS       = 8'hDA;
  localparam logic [7:0]  ORDER_INTEL    = 8'h49;
  localparam logic [7:0]  ORDER_MOTOROLA = 8'h4D;
  localparam logic [15:0] TIFF_MAGIC     = 16'd42;
  localparam logic [47:0] EXIF_ID        = 48'h45_78_69_66_00_00;

  typedef enum logic [3:0] {
    W_FIRST, W_SECOND, W_PREFIX, W_MARKER, W_LEN_HI, W_LEN_LO,
    W_SIG, W_SKIP, W_HEADER, W_DONE
  } walk_phase_t;

  typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_level_t;

  // one directed byte; fixed rows carry the answer word typed in
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       fixed;
    result_t    word;
  } stim_row_t;

  localparam result_t NO_ANSWER      = '{ST_FOUND, 1'b0, 32'd0, 32'd0};
  localparam result_t TOO_SHORT_WORD = '{ST_TOO_SHORT, 1'b0, 32'd0, 32'd0};
  localparam result_t NO_EXIF_WORD   = '{ST_NO_EXIF, 1'b0, 32'd0, 32'd0};
  localparam result_t MM_MAX_WORD    = '{ST_FOUND, 1'b0, 32'd0, 32'hFFFF_FFFF};

  localparam int DIRECTED_ROWS = 36;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // three-byte file, walk stops on a bad prefix but the file is too short
    '{8'hFF, 1'b0, 1'b0, NO_ANSWER},
    '{8'hD8, 1'b0, 1'b0, NO_ANSWER},
    '{8'h00, 1'b1, 1'b1, TOO_SHORT_WORD},
    // bare big-endian header, largest ifd offset, then a byte past the answer
    '{8'h4D, 1'b0, 1'b0, NO_ANSWER},
    '{8'h4D, 1'b0, 1'b0, NO_ANSWER},
    '{8'h00, 1'b0, 1'b0, NO_ANSWER},
    '{8'h2A, 1'b0, 1'b0, NO_ANSWER},
    '{8'hFF, 1'b0, 1'b0, NO_ANSWER},
    '{8'hFF, 1'b0, 1'b0, NO_ANSWER},
    '{8'hFF, 1'b0, 1'b0, NO_ANSWER},
    '{8'hFF, 1'b0, 1'b1, MM_MAX_WORD},
    '{8'h00, 1'b1, 1'b0, NO_ANSWER},
    // header cut short after four wrong bytes
    '{8'h00, 1'b0, 1'b0, NO_ANSWER},
    '{8'h00, 1'b0, 1'b0, NO_ANSWER},
    '{8'h00, 1'b0, 1'b0, NO_ANSWER},
    '{8'h00, 1'b1, 1'b1, TOO_SHORT_WORD},
    // short app1 skipped, then an exif signature ending on the final byte
    '{8'hFF, 1'b0, 1'b0, NO_ANSWER},
    '{8'hD8, 1'b0, 1'b0, NO_ANSWER},
    '{8'hFF, 1'b0, 1'b0, NO_ANSWER},
    '{8'hE1, 1'b0, 1'b0, NO_ANSWER},
    '{8'h00, 1'b0, 1'b0, NO_ANSWER},
    '{8'h02, 1'b0, 1'b0, NO_ANSWER},
    '{8'hFF, 1'b0, 1'b0, NO_ANSWER},
    '{8'hE1, 1'b0, 1'b0, NO_ANSWER},
    '{8'h00, 1'b0, 1'b0, NO_ANSWER},
    '{8'h08, 1'b0, 1'b0, NO_ANSWER},
    '{8'h45, 1'b0, 1'b0, NO_ANSWER},
    '{8'h78, 1'b0, 1'b0, NO_ANSWER},
    '{8'h69, 1'b0, 1'b0, NO_ANSWER},
    '{8'h66, 1'b0, 1'b0, NO_ANSWER},
    '{8'h00, 1'b0, 1'b0, NO_ANSWER},
    '{8'h00, 1'b1, 1'b1, NO_EXIF_WORD},
    // segment walk runs off the end of the file
    '{8'hFF, 1'b0, 1'b0, NO_ANSWER},
    '{8'hD8, 1'b0, 1'b0, NO_ANSWER},
    '{8'hFF, 1'b0, 1'b0, NO_ANSWER},
    '{8'hE0, 1'b1, 1'b1, NO_EXIF_WORD}
  };

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte   = 8'd0;
  logic        in_end_of_file = 1'b0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic [1:0]  out_status;
  logic        out_little_endian;
  logic [31:0] out_header_position;
  logic [31:0] out_first_ifd_offset;

  exif_tiff_header_locator_core DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_data_byte        (in_data_byte),
    .in_end_of_file      (in_end_of_file),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_little_endian   (out_little_endian),
    .out_header_position (out_header_position),
    .out_first_ifd_offset(out_first_ifd_offset)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // locator state kept by the testbench
  walk_phase_t walk_phase;
  logic [31:0] walk_count;
  logic [7:0]  walk_held;
  logic [7:0]  walk_marker;
  logic [15:0] walk_skip;
  logic        hdr_ok;
  logic [2:0]  hdr_idx;
  logic        hdr_little;
  logic [15:0] hdr_magic;
  logic [31:0] hdr_ifd;
  logic [31:0] hdr_start;
  logic        answer_ready;
  logic        answer_out;
  result_t     answer;

  result_t     expected_answers[$];
  logic [7:0]  file_bytes[$];
  result_t     want;
  idle_level_t gap_level   = IDLE_NONE;
  idle_level_t stall_level = IDLE_NONE;
  int          stall_left  = 0;
  int          quiet_cycles = 0;
  int          mismatches  = 0;
  int          bytes_sent  = 0;
  int          files_sent  = 0;
  int          answers_seen[4] = '{0, 0, 0, 0};

  task automatic locator_clear();
    walk_phase   = W_FIRST;
    walk_count   = '0;
    walk_held    = '0;
    walk_marker  = '0;
    walk_skip    = '0;
    hdr_ok       = 1'b1;
    hdr_idx      = '0;
    hdr_little   = 1'b0;
    hdr_magic    = '0;
    hdr_ifd      = '0;
    hdr_start    = '0;
    answer_ready = 1'b0;
    answer_out   = 1'b0;
    answer       = NO_ANSWER;
  endtask

  // a decision replaces any earlier one and may be reported again
  task automatic settle_answer(input status_t st);
    answer = NO_ANSWER;
    answer.status = st;
    if (st == ST_FOUND) begin
      answer.little_endian    = hdr_little;
      answer.header_position  = hdr_start;
      answer.first_ifd_offset = hdr_ifd;
    end
    answer_ready = 1'b1;
    answer_out   = 1'b0;
    walk_phase   = W_DONE;
  endtask

  task automatic open_header(input logic [31:0] start);
    hdr_start  = start;
    hdr_idx    = '0;
    hdr_ok     = 1'b1;
    hdr_magic  = '0;
    hdr_ifd    = '0;
    walk_phase = W_HEADER;
  endtask

  // order mark, magic and ifd offset, shifted in the file's byte order
  task automatic take_header_byte(input logic [7:0] b);
    logic [2:0] k;
    k = hdr_idx;
    if (k == 3'd0) begin
      walk_held = b;
    end else if (k == 3'd1) begin
      hdr_ok = (walk_held == b) && (b == ORDER_INTEL || b == ORDER_MOTOROLA);
      hdr_little = (b == ORDER_INTEL);
    end else if (k <= 3'd3) begin
      hdr_magic = hdr_little ? {b, hdr_magic[15:8]} : {hdr_magic[7:0], b};
    end else begin
      hdr_ifd = hdr_little ? {b, hdr_ifd[31:8]} : {hdr_ifd[23:0], b};
    end
    hdr_idx = k + 3'd1;
    if (k == 3'd7)
      settle_answer((hdr_ok && hdr_magic == TIFF_MAGIC) ? ST_FOUND : ST_BAD_HEADER);
  endtask

  // advance the locator by one byte and give the answer word it releases
  task automatic locate_byte(input logic [7:0] b, input logic last,
                             output logic has, output result_t word);
    logic [31:0] pos;
    logic [15:0] seg_len;
    pos  = walk_count;
    has  = 1'b0;
    word = NO_ANSWER;
    case (walk_phase)
      W_FIRST: begin
        walk_held  = b;
        walk_phase = W_SECOND;
      end
      W_SECOND: begin
        if (walk_held == MARK_PREFIX && b == MARK_SOI) begin
          walk_phase = W_PREFIX;
        end else begin
          open_header(32'd0);
          take_header_byte(walk_held);
          take_header_byte(b);
        end
      end
      W_PREFIX: begin
        if (b != MARK_PREFIX) settle_answer(ST_NO_EXIF);
        else walk_phase = W_MARKER;
      end
      W_MARKER: begin
        walk_marker = b;
        if (b == MARK_SOS) settle_answer(ST_NO_EXIF);
        else walk_phase = W_LEN_HI;
      end
      W_LEN_HI: begin
        walk_held  = b;
        walk_phase = W_LEN_LO;
      end
      W_LEN_LO: begin
        seg_len = {walk_held, b};
        if (seg_len < 16'd2) begin
          settle_answer(ST_NO_EXIF);
        end else begin
          walk_skip = seg_len - 16'd2;
          if (walk_marker == MARK_APP1 && seg_len >= 16'd8) begin
            hdr_idx    = '0;
            hdr_ok     = 1'b1;
            walk_phase = W_SIG;
          end else begin
            walk_phase = (walk_skip != 0) ? W_SKIP : W_PREFIX;
          end
        end
      end
      W_SIG: begin
        if (b != EXIF_ID[47 - 8 * hdr_idx -: 8]) hdr_ok = 1'b0;
        hdr_idx   = hdr_idx + 3'd1;
        walk_skip = walk_skip - 16'd1;
        if (hdr_idx >= 3'd6) begin
          if (hdr_ok) begin
            if (last) settle_answer(ST_NO_EXIF);
            else open_header(pos + 32'd1);
          end else begin
            hdr_idx    = '0;
            walk_phase = (walk_skip != 0) ? W_SKIP : W_PREFIX;
          end
        end
      end
      W_SKIP: begin
        walk_skip = walk_skip - 16'd1;
        if (walk_skip == 0) walk_phase = W_PREFIX;
      end
      W_HEADER: take_header_byte(b);
      default: ;
    endcase

    // final byte forces an answer; under four bytes it is always too short
    if (last) begin
      if (!answer_ready) begin
        if (walk_phase == W_HEADER || walk_phase == W_FIRST || walk_phase == W_SECOND)
          settle_answer(ST_TOO_SHORT);
        else
          settle_answer(ST_NO_EXIF);
      end
      if (pos < 32'd3) settle_answer(ST_TOO_SHORT);
    end

    if (answer_ready && (last || walk_phase == W_DONE) && !answer_out) begin
      has        = 1'b1;
      word       = answer;
      answer_out = 1'b1;
    end

    walk_count = walk_count + 32'd1;
    if (last) locator_clear();
  endtask

  // idle stretch length, mostly short and now and then long
  function automatic int idle_length(input idle_level_t level);
    int roll;
    roll = $urandom_range(0, 99);
    case (level)
      IDLE_LIGHT: begin
        if (roll < 70) return 0;
        if (roll < 96) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
      end
      IDLE_HEAVY: begin
        if (roll < 40) return 0;
        if (roll < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
      end
      default: return 0;
    endcase
  endfunction

  function automatic logic [7:0] other_marker();
    logic [7:0] m;
    m = 8'($urandom_range(8'hC0, 8'hFE));
    if (m == MARK_SOS || m == MARK_APP1) m = MARK_APP0;
    return m;
  endfunction

  task automatic put_segment(input logic [7:0] marker, input int body_len);
    logic [15:0] seg_len;
    seg_len = 16'(body_len + 2);
    file_bytes.push_back(MARK_PREFIX);
    file_bytes.push_back(marker);
    file_bytes.push_back(seg_len[15:8]);
    file_bytes.push_back(seg_len[7:0]);
    repeat (body_len) file_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // eight header bytes in a random byte order with an occasional damaged byte
  task automatic put_tiff_header();
    logic        le;
    logic [31:0] ifd;
    int          at;
    le = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: ifd = '0;
      1: ifd = '1;
      2: ifd = 32'($urandom_range(8, 64));
      default: ifd = $urandom;
    endcase
    at = file_bytes.size();
    if (le) begin
      file_bytes.push_back(ORDER_INTEL);
      file_bytes.push_back(ORDER_INTEL);
      file_bytes.push_back(TIFF_MAGIC[7:0]);
      file_bytes.push_back(TIFF_MAGIC[15:8]);
      for (int k = 0; k < 4; k++) file_bytes.push_back(ifd[8 * k +: 8]);
    end else begin
      file_bytes.push_back(ORDER_MOTOROLA);
      file_bytes.push_back(ORDER_MOTOROLA);
      file_bytes.push_back(TIFF_MAGIC[15:8]);
      file_bytes.push_back(TIFF_MAGIC[7:0]);
      for (int k = 3; k >= 0; k--) file_bytes.push_back(ifd[8 * k +: 8]);
    end
    if ($urandom_range(0, 6) == 0)
      file_bytes[at + $urandom_range(0, 7)] ^= 8'($urandom_range(1, 255));
  endtask

  // app1 segment carrying the exif id and a tiff header
  task automatic put_exif_segment(input logic spoil);
    int extra;
    int at;
    extra = $urandom_range(0, 4);
    file_bytes.push_back(MARK_PREFIX);
    file_bytes.push_back(MARK_APP1);
    file_bytes.push_back(8'h00);
    file_bytes.push_back(8'(16 + extra));
    at = file_bytes.size();
    for (int k = 0; k < 6; k++) file_bytes.push_back(EXIF_ID[47 - 8 * k -: 8]);
    if (spoil) file_bytes[at + $urandom_range(0, 5)] ^= 8'($urandom_range(1, 255));
    put_tiff_header();
    repeat (extra) file_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // drive one byte word, wait for it to be taken, queue its answer
  task automatic send_byte(input logic [7:0] b, input logic last,
                           input logic fixed, input result_t fixed_word);
    int      gap;
    logic    has;
    result_t word;
    gap = idle_length(gap_level);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data_byte   <= b;
    in_end_of_file <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    locate_byte(b, last, has, word);
    if (fixed) expected_answers.push_back(fixed_word);
    else if (has) expected_answers.push_back(word);
    bytes_sent++;
    if (last) files_sent++;
  endtask

  // hold the sender until every queued answer has come out
  task automatic drain_answers();
    in_valid <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk);
  endtask

  // result side: random stall and compare against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_answers.size() == 0) begin
          $error("answer word with none expected: status %0d", out_status);
          mismatches++;
        end else begin
          want = expected_answers.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            mismatches++;
          end
          if (out_little_endian !== want.little_endian) begin
            $error("little_endian: expected %0d, got %0d",
                   want.little_endian, out_little_endian);
            mismatches++;
          end
          if (out_header_position !== want.header_position) begin
            $error("header_position: expected %0h, got %0h",
                   want.header_position, out_header_position);
            mismatches++;
          end
          if (out_first_ifd_offset !== want.first_ifd_offset) begin
            $error("first_ifd_offset: expected %0h, got %0h",
                   want.first_ifd_offset, out_first_ifd_offset);
            mismatches++;
          end
          answers_seen[int'(want.status)]++;
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = idle_length(stall_level);
        if (stall_left != 0) begin
          stall_left--;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("no word moved for %0d cycles", QUIET_LIMIT);
        $display("FAIL exif_tiff_header_locator_core");
        $finish;
      end
    end
  end

  initial begin
    int nfile;
    int cut;
    locator_clear();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed files
    gap_level   = IDLE_LIGHT;
    stall_level = IDLE_LIGHT;
    for (int r = 0; r < DIRECTED_ROWS; r++)
      send_byte(DIRECTED[r].data, DIRECTED[r].last, DIRECTED[r].fixed, DIRECTED[r].word);
    drain_answers();

    // random files, mostly jpeg walks, some bare tiff headers and noise
    nfile = 0;
    while (bytes_sent < DIRECTED_ROWS + RANDOM_BYTES || nfile < RANDOM_FILES) begin
      if (nfile < 10) begin
        gap_level   = IDLE_NONE;
        stall_level = IDLE_NONE;
      end else if (nfile < 25) begin
        gap_level   = IDLE_LIGHT;
        stall_level = IDLE_LIGHT;
      end else begin
        gap_level   = IDLE_HEAVY;
        stall_level = IDLE_HEAVY;
      end
      if (nfile == 25) drain_answers();

      file_bytes.delete();
      case ($urandom_range(0, 9))
        0, 1: put_tiff_header();
        2: begin
          if ($urandom_range(0, 1) == 0) begin
            repeat ($urandom_range(1, 12)) file_bytes.push_back(8'($urandom_range(0, 255)));
          end else begin
            // segment length far beyond the end of the file
            file_bytes.push_back(MARK_PREFIX);
            file_bytes.push_back(MARK_SOI);
            file_bytes.push_back(MARK_PREFIX);
            file_bytes.push_back(other_marker());
            file_bytes.push_back(8'($urandom_range(1, 255)));
            file_bytes.push_back(8'($urandom_range(0, 255)));
          end
        end
        default: begin
          file_bytes.push_back(MARK_PREFIX);
          file_bytes.push_back(MARK_SOI);
          repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 5))
              0: put_segment(MARK_APP1, $urandom_range(0, 5));
              1: put_segment(MARK_APP1, $urandom_range(6, 12));
              2: put_exif_segment(1'b1);
              default: put_segment(other_marker(), $urandom_range(0, 8));
            endcase
          end
          case ($urandom_range(0, 9))
            0: begin
              file_bytes.push_back(MARK_PREFIX);
              file_bytes.push_back(MARK_SOS);
            end
            1: file_bytes.push_back(8'($urandom_range(0, 254)));
            2: begin
              // segment length below two
              file_bytes.push_back(MARK_PREFIX);
              file_bytes.push_back(other_marker());
              file_bytes.push_back(8'h00);
              file_bytes.push_back(8'($urandom_range(0, 1)));
            end
            default: put_exif_segment(1'b0);
          endcase
        end
      endcase
      repeat ($urandom_range(0, 4)) file_bytes.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 4) == 0) begin
        cut = $urandom_range(1, file_bytes.size());
        while (file_bytes.size() > cut) file_bytes.delete(file_bytes.size() - 1);
      end

      for (int i = 0; i < file_bytes.size(); i++)
        send_byte(file_bytes[i], i == file_bytes.size() - 1, 1'b0, NO_ANSWER);
      nfile++;
    end

    drain_answers();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d bytes in %0d files with idle gaps on input and stalls on output",
             bytes_sent, files_sent);
    $display("answers: %0d found, %0d no exif, %0d bad header, %0d too short",
             answers_seen[0], answers_seen[1], answers_seen[2], answers_seen[3]);
    if (mismatches == 0) begin
      $display("PASS exif_tiff_header_locator_core");
    end else begin
      $display("FAIL exif_tiff_header_locator_core");
    end
    $finish;
  end

endmodule
